[rtl/lfs_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none

package lfs_pkg;

	localparam int unsigned TimeWidth  = 48;
	localparam int unsigned DwellWidth = 32;
	localparam int unsigned LinkCount  = 3;
	localparam int unsigned CfgIdxWidth = 2;

	localparam logic [DwellWidth-1:0] DwellWifiReset = 32'd20000;
	localparam logic [DwellWidth-1:0] DwellCellReset = 32'd30000;
	localparam logic [DwellWidth-1:0] DwellLoraReset = 32'd0;

	// Links in rank order, best first.
	typedef enum logic [1:0] {
		LINK_WIFI = 2'd0,
		LINK_CELL = 2'd1,
		LINK_LORA = 2'd2,
		LINK_NONE = 2'd3
	} link_t;

	// Configuration register indexes.
	typedef enum logic [CfgIdxWidth-1:0] {
		REG_DWELL_WIFI = 2'd0,
		REG_DWELL_CELL = 2'd1,
		REG_DWELL_LORA = 2'd2,
		REG_UNUSED     = 2'd3
	} cfg_reg_t;

	// Per-link status handed from a tracker to the selector.
	typedef struct packed {
		logic up;
		logic ready;
	} link_stat_t;

endpackage

`default_nettype wire

[rtl/lfs_link_track.sv]
`timescale 1ns / 1ps
`default_nettype none

module lfs_link_track (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	input  wire logic                              en,
	input  wire logic                              up,
	input  wire logic [lfs_pkg::TimeWidth-1:0]     now,
	input  wire logic [lfs_pkg::DwellWidth-1:0]    dwell,
	output lfs_pkg::link_stat_t                    stat
);

	logic [lfs_pkg::TimeWidth-1:0] up_since_q;
	logic [lfs_pkg::TimeWidth-1:0] since_nxt;
	logic [lfs_pkg::TimeWidth-1:0] elapsed;

	// Zero marks "not up"; capture the time on the first up sample.
	always_comb begin
		if (!up) begin
			since_nxt = '0;
		end else if (up_since_q == '0) begin
			since_nxt = now;
		end else begin
			since_nxt = up_since_q;
		end
		elapsed    = now - since_nxt;
		stat.up    = up;
		stat.ready = elapsed >= {{(lfs_pkg::TimeWidth - lfs_pkg::DwellWidth){1'b0}}, dwell};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			up_since_q <= '0;
		end else if (en) begin
			up_since_q <= since_nxt;
		end
	end

endmodule

`default_nettype wire

[rtl/lfs_select.sv]
`timescale 1ns / 1ps
`default_nettype none

module lfs_select (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                en,
	input  wire lfs_pkg::link_stat_t stat [lfs_pkg::LinkCount],
	output lfs_pkg::link_t           link_nxt
);

	lfs_pkg::link_t current_q;
	lfs_pkg::link_t cur_eff;
	logic           cur_up;
	logic           cand_wifi;
	logic           cand_cell;

	always_comb begin
		unique case (current_q)
			lfs_pkg::LINK_WIFI: cur_up = stat[0].up;
			lfs_pkg::LINK_CELL: cur_up = stat[1].up;
			lfs_pkg::LINK_LORA: cur_up = stat[2].up;
			default:            cur_up = 1'b0;
		endcase
		// Treat the held link as none at once when it goes down.
		cur_eff   = cur_up ? current_q : lfs_pkg::LINK_NONE;
		cand_wifi = stat[0].up && stat[0].ready;
		cand_cell = stat[1].up && stat[1].ready;

		if (cur_eff == lfs_pkg::LINK_NONE) begin
			if (cand_wifi) begin
				link_nxt = lfs_pkg::LINK_WIFI;
			end else if (cand_cell) begin
				link_nxt = lfs_pkg::LINK_CELL;
			end else if (stat[2].up) begin
				link_nxt = lfs_pkg::LINK_LORA;
			end else begin
				link_nxt = lfs_pkg::LINK_NONE;
			end
		end else if (cand_wifi && cur_eff != lfs_pkg::LINK_WIFI) begin
			link_nxt = lfs_pkg::LINK_WIFI;
		end else if (cand_cell && cur_eff == lfs_pkg::LINK_LORA) begin
			link_nxt = lfs_pkg::LINK_CELL;
		end else begin
			link_nxt = cur_eff;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			current_q <= lfs_pkg::LINK_NONE;
		end else if (en) begin
			current_q <= link_nxt;
		end
	end

endmodule

`default_nettype wire

[rtl/link_failover_selector_core.sv]
`timescale 1ns / 1ps
`default_nettype none

// Link failover selector: picks the active link among Wi-Fi, cellular and LoRa.
// Input channel: in_valid / in_stall carry one item per handshake: a millisecond
// timestamp and three link-up flags. Output channel: out_valid / out_stall carry
// one item per input item, the chosen link (0 wifi, 1 cellular, 2 lora, 3 none).
// Configuration: cfg_we writes cfg_data into the dwell register at cfg_index
// (0 wifi, 1 cellular, 2 lora); index 3 is ignored. Write only while idle.
// Path: an accepted item is registered in the input stage, and its result is
// then registered in and presented from the output register.
// Throughput: one item per cycle while out_stall is low; the per-link dwell
// compares and the priority pick all resolve between input and output registers.
// Reset clears all link-up history, selects no link, and loads the dwell
// defaults (wifi 20000 ms, cellular 30000 ms, lora 0 ms).
// While the receiver stalls, the output item holds; one more item may still be
// taken into the input stage, after which in_stall rises until out_stall drops.
module link_failover_selector_core (
	input  wire logic                                clk,
	input  wire logic                                arst_n,
	input  wire logic                                in_valid,
	output      logic                                in_stall,
	input  wire logic [lfs_pkg::TimeWidth-1:0]       now_ms,
	input  wire logic                                wifi_up,
	input  wire logic                                cell_up,
	input  wire logic                                lora_up,
	output      logic                                out_valid,
	input  wire logic                                out_stall,
	output      logic [1:0]                          active_link,
	input  wire logic                                cfg_we,
	input  wire logic [lfs_pkg::CfgIdxWidth-1:0]     cfg_index,
	input  wire logic [lfs_pkg::DwellWidth-1:0]      cfg_data
);

	// Dwell registers.
	logic [lfs_pkg::DwellWidth-1:0] dwell_wifi_q;
	logic [lfs_pkg::DwellWidth-1:0] dwell_cell_q;
	logic [lfs_pkg::DwellWidth-1:0] dwell_lora_q;

	// Input stage.
	logic                          valid_s1;
	logic [lfs_pkg::TimeWidth-1:0] now_s1;
	logic                          wifi_up_s1;
	logic                          cell_up_s1;
	logic                          lora_up_s1;

	// Output register.
	logic           out_valid_q;
	lfs_pkg::link_t active_link_q;

	logic                advance;
	logic                step_en;
	lfs_pkg::link_stat_t stat [lfs_pkg::LinkCount];
	lfs_pkg::link_t      link_nxt;

	// The output register frees up when empty or when its item is taken.
	assign advance  = !out_valid_q || !out_stall;
	assign step_en  = valid_s1 && advance;
	assign in_stall = valid_s1 && !advance;

	assign out_valid   = out_valid_q;
	assign active_link = active_link_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dwell_wifi_q <= lfs_pkg::DwellWifiReset;
			dwell_cell_q <= lfs_pkg::DwellCellReset;
			dwell_lora_q <= lfs_pkg::DwellLoraReset;
		end else if (cfg_we) begin
			unique case (lfs_pkg::cfg_reg_t'(cfg_index))
				lfs_pkg::REG_DWELL_WIFI: dwell_wifi_q <= cfg_data;
				lfs_pkg::REG_DWELL_CELL: dwell_cell_q <= cfg_data;
				lfs_pkg::REG_DWELL_LORA: dwell_lora_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// Load the input stage whenever it is empty or moving on.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!in_stall) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && !in_stall) begin
			now_s1     <= now_ms;
			wifi_up_s1 <= wifi_up;
			cell_up_s1 <= cell_up;
			lora_up_s1 <= lora_up;
		end
	end

	// Per-link up-time trackers; history advances once per item.
	lfs_link_track u_track_wifi (
		.clk    (clk),
		.arst_n (arst_n),
		.en     (step_en),
		.up     (wifi_up_s1),
		.now    (now_s1),
		.dwell  (dwell_wifi_q),
		.stat   (stat[0])
	);

	lfs_link_track u_track_cell (
		.clk    (clk),
		.arst_n (arst_n),
		.en     (step_en),
		.up     (cell_up_s1),
		.now    (now_s1),
		.dwell  (dwell_cell_q),
		.stat   (stat[1])
	);

	lfs_link_track u_track_lora (
		.clk    (clk),
		.arst_n (arst_n),
		.en     (step_en),
		.up     (lora_up_s1),
		.now    (now_s1),
		.dwell  (dwell_lora_q),
		.stat   (stat[2])
	);

	// Drop, fall back or upgrade, and hold the chosen link.
	lfs_select u_select (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (step_en),
		.stat     (stat),
		.link_nxt (link_nxt)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (step_en) begin
			active_link_q <= link_nxt;
		end
	end

	// Stall only while an item waits in the input stage.
	a_stall_needs_item: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> valid_s1)
		else $error("input stalled with an empty input stage");

	// A fresh result always comes from an item that left the input stage.
	a_result_from_item: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(valid_s1))
		else $error("result appeared without a source item");

	// The chosen link is never one reported down in the same item.
	a_link_is_up: assert property (@(posedge clk) disable iff (!arst_n)
		step_en |=> ((active_link_q != lfs_pkg::LINK_WIFI || $past(wifi_up_s1)) &&
			(active_link_q != lfs_pkg::LINK_CELL || $past(cell_up_s1)) &&
			(active_link_q != lfs_pkg::LINK_LORA || $past(lora_up_s1))))
		else $error("selected a link that was down");

endmodule

`default_nettype wire
